[rtl/ucdp_pkg.sv]
package ucdp_pkg;

    localparam logic [7:0] DT_CONFIG    = 8'h02;
    localparam logic [7:0] DT_INTERFACE = 8'h04;
    localparam logic [7:0] DT_ENDPOINT  = 8'h05;

    localparam logic [2:0] FOUND_IF   = 3'h1;
    localparam logic [2:0] FOUND_BIN  = 3'h2;
    localparam logic [2:0] FOUND_BOUT = 3'h4;
    localparam logic [2:0] FOUND_ALL  = 3'h7;

    localparam logic [1:0] XFER_BULK = 2'b10;

    localparam logic [7:0] HDR_MIN_LEN  = 8'd4;
    localparam logic [7:0] DESC_MIN_LEN = 8'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_CONFIG = 3'd1,
        ST_DUP_OUT    = 3'd2,
        ST_DUP_IN     = 3'd3,
        ST_INCOMPLETE = 3'd4,
        ST_MALFORMED  = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic [7:0]  offset;
        logic [7:0]  cur_len;
        logic [7:0]  cur_type;
        logic [15:0] remaining;
        logic        in_header;
        logic [2:0]  found;
        logic [7:0]  pend_addr;
        logic [7:0]  pend_attr;
        logic [15:0] pend_size;
        logic [7:0]  if_num;
        logic [3:0]  in_num;
        logic [15:0] in_mps;
        logic [7:0]  in_ival;
        logic [3:0]  out_num;
        logic [15:0] out_mps;
        logic [7:0]  out_ival;
        logic        done;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{in_header: 1'b1, default: '0};

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  found_mask;
        logic [7:0]  interface_number;
        logic [3:0]  in_endpoint_number;
        logic [15:0] in_max_packet;
        logic [7:0]  in_poll_interval;
        logic [3:0]  out_endpoint_number;
        logic [15:0] out_max_packet;
        logic [7:0]  out_poll_interval;
    } result_t;

endpackage

[rtl/ucdp_in_if.sv]
interface ucdp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

[rtl/ucdp_out_if.sv]
interface ucdp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [2:0]  found_mask;
    logic [7:0]  interface_number;
    logic [3:0]  in_endpoint_number;
    logic [15:0] in_max_packet;
    logic [7:0]  in_poll_interval;
    logic [3:0]  out_endpoint_number;
    logic [15:0] out_max_packet;
    logic [7:0]  out_poll_interval;

    modport source (output valid, status, found_mask, interface_number,
        in_endpoint_number, in_max_packet, in_poll_interval,
        out_endpoint_number, out_max_packet, out_poll_interval, input ready);
    modport sink (input valid, status, found_mask, interface_number,
        in_endpoint_number, in_max_packet, in_poll_interval,
        out_endpoint_number, out_max_packet, out_poll_interval, output ready);
endinterface

[rtl/usb_config_descriptor_bulk_pair_parser_unit.sv]
// A result beat passes from the input register through the combinational parse step into
// the result register; a byte is parsed only while the result register is empty or drains.
// Throughput: one descriptor byte per cycle through the parse step between the input
// register and the result register, while no result is held; a held result stalls the input.
// Reset clears the input and output valid flags and returns the parser to
// expecting a configuration header.
module usb_config_descriptor_bulk_pair_parser_unit (
    input  logic      clk,
    input  logic      rst_n,
    ucdp_in_if.sink   desc,
    ucdp_out_if.source result
);

    logic                   beat_valid;
    ucdp_pkg::beat_t        beat;
    logic                   process;
    ucdp_pkg::parse_state_t state_reg;
    ucdp_pkg::parse_state_t state_next;
    logic                   step_hit;
    ucdp_pkg::result_t      step_res;
    logic                   out_vld_reg;
    logic                   out_vld_next;
    ucdp_pkg::result_t      out_reg;

    assign process = beat_valid && (!out_vld_reg || result.ready);

    ucdp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc       (desc),
        .advance    (process),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    ucdp_parse_step u_parse_step (
        .state      (state_reg),
        .beat       (beat),
        .state_next (state_next),
        .hit        (step_hit),
        .res        (step_res)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (process && step_hit)
        begin
            out_vld_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ucdp_pkg::PARSE_RESET;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            if (process)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && step_hit)
        begin
            out_reg <= step_res;
        end
    end

    assign result.valid               = out_vld_reg;
    assign result.status              = out_reg.status;
    assign result.found_mask          = out_reg.found_mask;
    assign result.interface_number    = out_reg.interface_number;
    assign result.in_endpoint_number  = out_reg.in_endpoint_number;
    assign result.in_max_packet       = out_reg.in_max_packet;
    assign result.in_poll_interval    = out_reg.in_poll_interval;
    assign result.out_endpoint_number = out_reg.out_endpoint_number;
    assign result.out_max_packet      = out_reg.out_max_packet;
    assign result.out_poll_interval   = out_reg.out_poll_interval;

    a_hit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        process && step_hit |=> out_vld_reg)
        else $error("parse result was not loaded into the output register");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        process && state_reg.done && !beat.first_byte |=> state_reg.done)
        else $error("finished parse restarted without a first byte");

    a_ok_means_all: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_reg.status == ucdp_pkg::ST_OK |->
        out_reg.found_mask == ucdp_pkg::FOUND_ALL)
        else $error("ok status without interface and both bulk endpoints");

    a_header_nothing_found: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.in_header |-> state_reg.found == 3'd0)
        else $error("descriptor found while still in the header");

endmodule

[rtl/ucdp_in_stage.sv]
module ucdp_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    ucdp_in_if.sink         desc,
    input  logic            advance,
    output logic            beat_valid,
    output ucdp_pkg::beat_t beat
);

    logic            vld_reg;
    logic            vld_next;
    ucdp_pkg::beat_t beat_reg;
    logic            take;

    assign desc.ready = !vld_reg || advance;
    assign take       = desc.valid && desc.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (advance)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg.data_byte  <= desc.data_byte;
            beat_reg.first_byte <= desc.first_byte;
            beat_reg.last_byte  <= desc.last_byte;
        end
    end

    assign beat_valid = vld_reg;
    assign beat       = beat_reg;

endmodule

[rtl/ucdp_parse_step.sv]
module ucdp_parse_step (
    input  ucdp_pkg::parse_state_t state,
    input  ucdp_pkg::beat_t        beat,
    output ucdp_pkg::parse_state_t state_next,
    output logic                   hit,
    output ucdp_pkg::result_t      res
);

    ucdp_pkg::parse_state_t cur;
    ucdp_pkg::parse_state_t nxt;
    ucdp_pkg::status_t      code;
    logic                   err;
    logic [7:0]             d;
    logic [7:0]             off;
    logic [15:0]            total;
    logic                   at_end;

    always_comb
    begin
        cur    = beat.first_byte ? ucdp_pkg::PARSE_RESET : state;
        nxt    = cur;
        d      = beat.data_byte;
        off    = cur.offset;
        code   = ucdp_pkg::ST_OK;
        err    = 1'b0;
        total  = {d, cur.pend_size[7:0]};
        at_end = 1'b0;

        if (!cur.done)
        begin
            if (cur.in_header)
            begin
                case (off)
                    8'd0:
                    begin
                        nxt.cur_len = d;
                        if (d < ucdp_pkg::HDR_MIN_LEN)
                        begin
                            err  = 1'b1;
                            code = ucdp_pkg::ST_MALFORMED;
                        end
                    end
                    8'd1:
                    begin
                        nxt.cur_type = d;
                        if (d != ucdp_pkg::DT_CONFIG)
                        begin
                            err  = 1'b1;
                            code = ucdp_pkg::ST_NOT_CONFIG;
                        end
                    end
                    8'd2:
                    begin
                        nxt.pend_size = {8'd0, d};
                    end
                    8'd3:
                    begin
                        nxt.remaining = (total >= 16'd4) ? total - 16'd4 : 16'd0;
                    end
                    default:
                    begin
                        if (cur.remaining != 16'd0)
                        begin
                            nxt.remaining = cur.remaining - 16'd1;
                        end
                    end
                endcase
            end
            else
            begin
                if (cur.remaining != 16'd0)
                begin
                    nxt.remaining = cur.remaining - 16'd1;
                end
                if (off == 8'd0)
                begin
                    nxt.cur_len = d;
                    if (d < ucdp_pkg::DESC_MIN_LEN)
                    begin
                        err  = 1'b1;
                        code = ucdp_pkg::ST_MALFORMED;
                    end
                end
                else if (off == 8'd1)
                begin
                    nxt.cur_type = d;
                end
                else if (cur.cur_type == ucdp_pkg::DT_INTERFACE)
                begin
                    if (off == 8'd2)
                    begin
                        nxt.if_num = d;
                        nxt.found  = ucdp_pkg::FOUND_IF;
                    end
                end
                else if (cur.cur_type == ucdp_pkg::DT_ENDPOINT)
                begin
                    case (off)
                        8'd2: nxt.pend_addr = d;
                        8'd3: nxt.pend_attr = d;
                        8'd4: nxt.pend_size = {8'd0, d};
                        8'd5: nxt.pend_size = {d, cur.pend_size[7:0]};
                        8'd6:
                        begin
                            if (cur.pend_attr[1:0] == ucdp_pkg::XFER_BULK)
                            begin
                                if (!cur.pend_addr[7])
                                begin
                                    if ((cur.found & ucdp_pkg::FOUND_BOUT) != 3'd0)
                                    begin
                                        err  = 1'b1;
                                        code = ucdp_pkg::ST_DUP_OUT;
                                    end
                                    else
                                    begin
                                        nxt.found    = cur.found | ucdp_pkg::FOUND_BOUT;
                                        nxt.out_num  = cur.pend_addr[3:0];
                                        nxt.out_mps  = cur.pend_size;
                                        nxt.out_ival = d;
                                    end
                                end
                                else
                                begin
                                    if ((cur.found & ucdp_pkg::FOUND_BIN) != 3'd0)
                                    begin
                                        err  = 1'b1;
                                        code = ucdp_pkg::ST_DUP_IN;
                                    end
                                    else
                                    begin
                                        nxt.found   = cur.found | ucdp_pkg::FOUND_BIN;
                                        nxt.in_num  = cur.pend_addr[3:0];
                                        nxt.in_mps  = cur.pend_size;
                                        nxt.in_ival = d;
                                    end
                                end
                                if (!err && nxt.found == ucdp_pkg::FOUND_ALL)
                                begin
                                    err  = 1'b1;
                                    code = ucdp_pkg::ST_OK;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            if (!err)
            begin
                at_end = ({1'b0, off} + 9'd1) >= {1'b0, nxt.cur_len};
                if (at_end)
                begin
                    nxt.in_header = 1'b0;
                    nxt.offset    = 8'd0;
                    if (nxt.remaining < 16'd2)
                    begin
                        err  = 1'b1;
                        code = ucdp_pkg::ST_INCOMPLETE;
                    end
                end
                else
                begin
                    nxt.offset = off + 8'd1;
                end
            end

            if (!err && beat.last_byte)
            begin
                err  = 1'b1;
                code = ucdp_pkg::ST_INCOMPLETE;
            end

            if (err)
            begin
                nxt.done = 1'b1;
            end
        end

        state_next = nxt;
        hit        = err;

        res.status              = code;
        res.found_mask          = nxt.found;
        res.interface_number    = nxt.found[0] ? nxt.if_num : 8'd0;
        res.in_endpoint_number  = nxt.found[1] ? nxt.in_num : 4'd0;
        res.in_max_packet       = nxt.found[1] ? nxt.in_mps : 16'd0;
        res.in_poll_interval    = nxt.found[1] ? nxt.in_ival : 8'd0;
        res.out_endpoint_number = nxt.found[2] ? nxt.out_num : 4'd0;
        res.out_max_packet      = nxt.found[2] ? nxt.out_mps : 16'd0;
        res.out_poll_interval   = nxt.found[2] ? nxt.out_ival : 8'd0;
    end

endmodule

[verif/usb_config_descriptor_bulk_pair_parser_unit_tb.sv]
module usb_config_descriptor_bulk_pair_parser_unit_tb;
    import ucdp_pkg::*;

    localparam int RANDOM_BEATS   = 1200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_CYCLES   = 200;
    localparam int DIRECTED_COUNT = 27;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       typed;
        status_t    st;
    } row_t;

    typedef enum int {
        P_IFACE,
        P_BULK_IN,
        P_BULK_OUT,
        P_OTHER_EP,
        P_OTHER,
        P_BROKEN
    } piece_t;

    // Rows marked typed carry a status that is obvious at a glance; every
    // other field of those reports is zero.
    localparam row_t DIRECTED [DIRECTED_COUNT] = '{
        '{8'h03, 1'b0, 1'b0, 1'b1, ST_MALFORMED},
        '{8'h04, 1'b1, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, 1'b1, ST_NOT_CONFIG},
        '{8'h00, 1'b1, 1'b1, 1'b1, ST_MALFORMED},
        '{8'h04, 1'b1, 1'b0, 1'b0, ST_OK},
        '{8'h02, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b0, 1'b1, ST_MALFORMED},
        '{8'h04, 1'b1, 1'b0, 1'b0, ST_OK},
        '{8'h02, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h15, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h03, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h04, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h07, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h05, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h8F, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFE, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h04, 1'b1, 1'b0, 1'b0, ST_OK},
        '{8'h02, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h04, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b1, ST_INCOMPLETE}
    };

    logic clk = 1'b0;
    logic rst_n;

    ucdp_in_if  desc_ch();
    ucdp_out_if result_ch();

    usb_config_descriptor_bulk_pair_parser_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .desc   (desc_ch.sink),
        .result (result_ch.source)
    );

    always #5 clk = ~clk;

    logic [7:0]  byte_pos;
    logic [7:0]  desc_len;
    logic [7:0]  desc_type;
    logic [16:0] bytes_left;
    logic        reading_header;
    logic [2:0]  found;
    logic [7:0]  ep_addr;
    logic [7:0]  ep_attr;
    logic [15:0] ep_size;
    logic [7:0]  if_num;
    logic [3:0]  in_num;
    logic [15:0] in_mps;
    logic [7:0]  in_ival;
    logic [3:0]  out_num;
    logic [15:0] out_mps;
    logic [7:0]  out_ival;
    logic        set_closed;

    result_t    parse_reports[$];
    logic [7:0] set_bytes[$];

    int  failures     = 0;
    int  beats_sent   = 0;
    int  parsed_beats = 0;
    int  sets_sent    = 0;
    int  reports_seen = 0;
    int  ok_reports   = 0;
    bit  calm         = 1'b0;

    function automatic void restart_parse();
        byte_pos       = 8'd0;
        desc_len       = 8'd0;
        desc_type      = 8'd0;
        bytes_left     = 17'd0;
        reading_header = 1'b1;
        found          = 3'd0;
        ep_addr        = 8'd0;
        ep_attr        = 8'd0;
        ep_size        = 16'd0;
        if_num         = 8'd0;
        in_num         = 4'd0;
        in_mps         = 16'd0;
        in_ival        = 8'd0;
        out_num        = 4'd0;
        out_mps        = 16'd0;
        out_ival       = 8'd0;
        set_closed     = 1'b0;
    endfunction

    function automatic bit walk_descriptor_byte(input beat_t b, output result_t rep);
        logic [7:0]  d;
        logic [7:0]  off;
        logic [16:0] total;
        bit          decided;
        status_t     st;
        d = b.data_byte;
        total = 17'd0;
        decided = 1'b0;
        st = ST_OK;
        rep = '0;
        if (b.first_byte)
            restart_parse();
        if (set_closed)
            return 1'b0;
        parsed_beats++;
        off = byte_pos;
        if (reading_header)
        begin
            case (off)
                8'd0:
                begin
                    desc_len = d;
                    if (d < HDR_MIN_LEN)
                    begin
                        decided = 1'b1;
                        st = ST_MALFORMED;
                    end
                end
                8'd1:
                begin
                    desc_type = d;
                    if (d != DT_CONFIG)
                    begin
                        decided = 1'b1;
                        st = ST_NOT_CONFIG;
                    end
                end
                8'd2:
                    ep_size = {8'd0, d};
                8'd3:
                begin
                    total = {1'b0, d, ep_size[7:0]};
                    bytes_left = (total >= 17'd4) ? total - 17'd4 : 17'd0;
                end
                default:
                    if (bytes_left != 17'd0)
                        bytes_left = bytes_left - 17'd1;
            endcase
        end
        else
        begin
            if (bytes_left != 17'd0)
                bytes_left = bytes_left - 17'd1;
            if (off == 8'd0)
            begin
                desc_len = d;
                if (d < DESC_MIN_LEN)
                begin
                    decided = 1'b1;
                    st = ST_MALFORMED;
                end
            end
            else if (off == 8'd1)
                desc_type = d;
            else if (desc_type == DT_INTERFACE)
            begin
                if (off == 8'd2)
                begin
                    if_num = d;
                    found = FOUND_IF;
                end
            end
            else if (desc_type == DT_ENDPOINT)
            begin
                case (off)
                    8'd2: ep_addr = d;
                    8'd3: ep_attr = d;
                    8'd4: ep_size = {8'd0, d};
                    8'd5: ep_size = {d, ep_size[7:0]};
                    8'd6:
                    begin
                        if (ep_attr[1:0] == XFER_BULK)
                        begin
                            if (!ep_addr[7])
                            begin
                                if ((found & FOUND_BOUT) != 3'd0)
                                begin
                                    decided = 1'b1;
                                    st = ST_DUP_OUT;
                                end
                                else
                                begin
                                    found = found | FOUND_BOUT;
                                    out_num = ep_addr[3:0];
                                    out_mps = ep_size;
                                    out_ival = d;
                                end
                            end
                            else
                            begin
                                if ((found & FOUND_BIN) != 3'd0)
                                begin
                                    decided = 1'b1;
                                    st = ST_DUP_IN;
                                end
                                else
                                begin
                                    found = found | FOUND_BIN;
                                    in_num = ep_addr[3:0];
                                    in_mps = ep_size;
                                    in_ival = d;
                                end
                            end
                            if (!decided && found == FOUND_ALL)
                            begin
                                decided = 1'b1;
                                st = ST_OK;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!decided)
        begin
            if (int'(off) + 1 >= int'(desc_len))
            begin
                reading_header = 1'b0;
                byte_pos = 8'd0;
                if (bytes_left < 17'd2)
                begin
                    decided = 1'b1;
                    st = ST_INCOMPLETE;
                end
            end
            else
                byte_pos = off + 8'd1;
        end
        if (!decided && b.last_byte)
        begin
            decided = 1'b1;
            st = ST_INCOMPLETE;
        end
        if (!decided)
            return 1'b0;
        set_closed = 1'b1;
        rep.status = st;
        rep.found_mask = found;
        if ((found & FOUND_IF) != 3'd0)
            rep.interface_number = if_num;
        if ((found & FOUND_BIN) != 3'd0)
        begin
            rep.in_endpoint_number = in_num;
            rep.in_max_packet = in_mps;
            rep.in_poll_interval = in_ival;
        end
        if ((found & FOUND_BOUT) != 3'd0)
        begin
            rep.out_endpoint_number = out_num;
            rep.out_max_packet = out_mps;
            rep.out_poll_interval = out_ival;
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input beat_t b, input bit typed, input status_t typed_st);
        result_t rep;
        bit      decided;
        calm = beats_sent >= 500 && beats_sent < 750;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 30)
        begin
            desc_ch.valid <= 1'b0;
            @(negedge clk);
        end
        desc_ch.valid      <= 1'b1;
        desc_ch.data_byte  <= b.data_byte;
        desc_ch.first_byte <= b.first_byte;
        desc_ch.last_byte  <= b.last_byte;
        do
            @(posedge clk);
        while (!desc_ch.ready);
        beats_sent++;
        decided = walk_descriptor_byte(b, rep);
        if (typed)
        begin
            rep = '0;
            rep.status = typed_st;
        end
        if (decided || typed)
            parse_reports.push_back(rep);
    endtask

    task automatic add_piece(input piece_t kind);
        logic [7:0] fields [6];
        logic [7:0] addr;
        logic [7:0] attr;
        logic [7:0] kind_code;
        int         nf;
        int         len;
        nf = 0;
        len = 1;
        addr = 8'($urandom);
        attr = 8'($urandom);
        case (kind)
            P_IFACE:
            begin
                len = ($urandom_range(9) == 0) ? int'($urandom_range(2, 12)) : 9;
                fields[0] = DT_INTERFACE;
                fields[1] = 8'($urandom);
                nf = 2;
            end
            P_BULK_IN, P_BULK_OUT, P_OTHER_EP:
            begin
                len = ($urandom_range(6) == 0) ? int'($urandom_range(2, 10)) : 7;
                if (kind == P_OTHER_EP)
                begin
                    attr[1:0] = 2'($urandom_range(2));
                    if (attr[1:0] == XFER_BULK)
                        attr[1:0] = 2'b11;
                end
                else
                begin
                    addr[7] = (kind == P_BULK_IN);
                    attr[1:0] = XFER_BULK;
                end
                fields[0] = DT_ENDPOINT;
                fields[1] = addr;
                fields[2] = attr;
                fields[3] = 8'($urandom);
                fields[4] = 8'($urandom);
                fields[5] = 8'($urandom);
                nf = 6;
            end
            P_OTHER:
            begin
                len = $urandom_range(2, 12);
                kind_code = 8'($urandom);
                if (kind_code == DT_INTERFACE || kind_code == DT_ENDPOINT)
                    kind_code = 8'h24;
                fields[0] = kind_code;
                nf = 1;
            end
            default:
                len = $urandom_range(1);
        endcase
        set_bytes.push_back(8'(len));
        for (int i = 1; i < len; i++)
            set_bytes.push_back((i <= nf) ? fields[i - 1] : 8'($urandom));
    endtask

    task automatic send_random_set();
        beat_t b;
        int    roll;
        int    hlen;
        int    total;
        int    stop;
        bit    mark_last;
        sets_sent++;
        set_bytes.delete();
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(1, 24))
            begin
                b.data_byte = 8'($urandom);
                b.first_byte = ($urandom_range(3) == 0);
                b.last_byte = ($urandom_range(7) == 0);
                send_beat(b, 1'b0, ST_OK);
            end
            return;
        end
        roll = $urandom_range(99);
        if (roll < 85)
            hlen = 9;
        else if (roll < 93)
            hlen = $urandom_range(4, 8);
        else if (roll < 98)
            hlen = $urandom_range(3);
        else
            hlen = $urandom_range(10, 40);
        set_bytes.push_back(8'(hlen));
        set_bytes.push_back(($urandom_range(19) == 0) ? 8'($urandom) : DT_CONFIG);
        set_bytes.push_back(8'd0);
        set_bytes.push_back(8'd0);
        for (int i = 4; i < hlen; i++)
            set_bytes.push_back(8'($urandom));
        if ($urandom_range(99) < 60)
        begin
            if ($urandom_range(2) == 0)
                add_piece(P_OTHER);
            add_piece(P_IFACE);
            if ($urandom_range(3) == 0)
                add_piece(($urandom_range(1) == 0) ? P_OTHER_EP : P_OTHER);
            if ($urandom_range(1) == 0)
            begin
                add_piece(P_BULK_IN);
                add_piece(P_BULK_OUT);
            end
            else
            begin
                add_piece(P_BULK_OUT);
                add_piece(P_BULK_IN);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                roll = $urandom_range(19);
                if (roll < 5)
                    add_piece(P_IFACE);
                else if (roll < 10)
                    add_piece(P_BULK_IN);
                else if (roll < 15)
                    add_piece(P_BULK_OUT);
                else if (roll < 17)
                    add_piece(P_OTHER_EP);
                else if (roll < 19)
                    add_piece(P_OTHER);
                else
                    add_piece(P_BROKEN);
            end
        end
        total = set_bytes.size();
        roll = $urandom_range(99);
        if (roll < 10)
            total = $urandom_range(total);
        else if (roll < 20)
            total = $urandom_range(65535);
        set_bytes[2] = 8'(total);
        set_bytes[3] = 8'(total >> 8);
        stop = set_bytes.size();
        if ($urandom_range(9) == 0)
            stop = $urandom_range(1, stop);
        mark_last = ($urandom_range(99) < 85);
        for (int i = 0; i < stop; i++)
        begin
            b.data_byte = set_bytes[i];
            b.first_byte = (i == 0);
            b.last_byte = mark_last && (i == stop - 1);
            send_beat(b, 1'b0, ST_OK);
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            got.status              = result_ch.status;
            got.found_mask          = result_ch.found_mask;
            got.interface_number    = result_ch.interface_number;
            got.in_endpoint_number  = result_ch.in_endpoint_number;
            got.in_max_packet       = result_ch.in_max_packet;
            got.in_poll_interval    = result_ch.in_poll_interval;
            got.out_endpoint_number = result_ch.out_endpoint_number;
            got.out_max_packet      = result_ch.out_max_packet;
            got.out_poll_interval   = result_ch.out_poll_interval;
            reports_seen++;
            if (parse_reports.size() == 0)
            begin
                $error("Result beat with status %0d arrived with no report pending.",
                       got.status);
                failures++;
            end
            else
            begin
                want = parse_reports.pop_front();
                if (want.status == ST_OK)
                    ok_reports++;
                check_field("status", 16'(want.status), 16'(got.status));
                check_field("found_mask", 16'(want.found_mask), 16'(got.found_mask));
                check_field("interface_number", 16'(want.interface_number),
                            16'(got.interface_number));
                check_field("in_endpoint_number", 16'(want.in_endpoint_number),
                            16'(got.in_endpoint_number));
                check_field("in_max_packet", want.in_max_packet, got.in_max_packet);
                check_field("in_poll_interval", 16'(want.in_poll_interval),
                            16'(got.in_poll_interval));
                check_field("out_endpoint_number", 16'(want.out_endpoint_number),
                            16'(got.out_endpoint_number));
                check_field("out_max_packet", want.out_max_packet, got.out_max_packet);
                check_field("out_poll_interval", 16'(want.out_poll_interval),
                            16'(got.out_poll_interval));
            end
        end
    end

    // The receiver stalls once for a long stretch so that the block backs up.
    initial
    begin
        int  stall_left;
        bit  stalled_once;
        stall_left = 0;
        stalled_once = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (!stalled_once && beats_sent >= 300)
            begin
                stalled_once = 1'b1;
                stall_left = STALL_CYCLES - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= 30);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((desc_ch.valid === 1'b1 && desc_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("No beat accepted for %0d cycles.", WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        beat_t b;
        rst_n = 1'b0;
        desc_ch.valid = 1'b0;
        desc_ch.data_byte = 8'd0;
        desc_ch.first_byte = 1'b0;
        desc_ch.last_byte = 1'b0;
        restart_parse();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            b.data_byte = DIRECTED[i].data;
            b.first_byte = DIRECTED[i].first;
            b.last_byte = DIRECTED[i].last;
            send_beat(b, DIRECTED[i].typed, DIRECTED[i].st);
        end
        while (beats_sent < DIRECTED_COUNT + RANDOM_BEATS)
            send_random_set();
        @(negedge clk);
        desc_ch.valid <= 1'b0;
        while (parse_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d descriptor beats (%0d parsed) over %0d random sets.",
                 beats_sent, parsed_beats, sets_sent);
        $display("Checked %0d reports, %0d of them complete bulk pairs.",
                 reports_seen, ok_reports);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[filelist.f]
rtl/ucdp_pkg.sv
rtl/ucdp_in_if.sv
rtl/ucdp_out_if.sv
rtl/ucdp_in_stage.sv
rtl/ucdp_parse_step.sv
rtl/usb_config_descriptor_bulk_pair_parser_unit.sv
verif/usb_config_descriptor_bulk_pair_parser_unit_tb.sv
